// ----- rtl/rhp_pkg.sv -----
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types, codes and defaults for the rudder homing positioner.
// ----------------------------------------------------------------------------
package rhp_pkg;

    // Defaults for the top-level parameters
    localparam int POSITION_BITS_DEF = 8;
    localparam int TIMER_BITS_DEF    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEER_W    = 16;
    localparam int PAUSE_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STEER_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_PAUSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_PAUSE  = 2'd2;

    localparam logic [STEER_W-1:0] STEER_TIMEOUT_RST = 16'd488;
    localparam logic [PAUSE_W-1:0] STARTUP_PAUSE_RST = 8'd244;
    localparam logic [PAUSE_W-1:0] SETTLE_PAUSE_RST  = 8'd62;

    // Settle ticks at which the right end is sampled
    localparam logic [PAUSE_W-1:0] SETTLE_SAMPLE_A = 8'd10;
    localparam logic [PAUSE_W-1:0] SETTLE_SAMPLE_B = 8'd20;

    // Reset values of the calibrated ends, before saturation
    localparam int LEFT_END_RST  = 100;
    localparam int RIGHT_END_RST = -100;

    // Motor command codes
    localparam logic [1:0] DRIVE_STOP  = 2'd0;
    localparam logic [1:0] DRIVE_LEFT  = 2'd1;
    localparam logic [1:0] DRIVE_RIGHT = 2'd2;

    // Report kinds
    localparam logic KIND_REACHED = 1'b0;
    localparam logic KIND_FAILED  = 1'b1;

    // Mode codes as seen on the result channel
    localparam logic [2:0] MODE_CODE_STARTUP = 3'd0;
    localparam logic [2:0] MODE_CODE_HOMING  = 3'd1;
    localparam logic [2:0] MODE_CODE_LEFT    = 3'd2;
    localparam logic [2:0] MODE_CODE_RIGHT   = 3'd3;
    localparam logic [2:0] MODE_CODE_REACHED = 3'd4;
    localparam logic [2:0] MODE_CODE_FAILED  = 3'd5;
    localparam logic [2:0] MODE_CODE_IDLE    = 3'd6;

    typedef enum logic [6:0] {
        M_STARTUP = 7'b0000001,
        M_HOMING  = 7'b0000010,
        M_LEFT    = 7'b0000100,
        M_RIGHT   = 7'b0001000,
        M_REACHED = 7'b0010000,
        M_FAILED  = 7'b0100000,
        M_IDLE    = 7'b1000000
    } mode_t;

    typedef enum logic [5:0] {
        H_FIND_LEFT    = 6'b000001,
        H_LEFT_SETTLE  = 6'b000010,
        H_FIND_RIGHT   = 6'b000100,
        H_RIGHT_SETTLE = 6'b001000,
        H_FIND_MID     = 6'b010000,
        H_MID_DONE     = 6'b100000
    } home_t;

    // Control state handed between the top level and the step logic
    typedef struct packed {
        mode_t      mode;
        home_t      home;
        logic [1:0] drive;
        logic       cmd_pending;
        logic       fail_reported;
    } rhp_ctrl_t;

    // Configuration values
    typedef struct packed {
        logic [STEER_W-1:0] steer_timeout;
        logic [PAUSE_W-1:0] startup_pause;
        logic [PAUSE_W-1:0] settle_pause;
    } rhp_cfg_t;

    function automatic logic [2:0] mode_code(mode_t m);
        logic [2:0] c;
        unique case (m)
            M_STARTUP: c = MODE_CODE_STARTUP;
            M_HOMING:  c = MODE_CODE_HOMING;
            M_LEFT:    c = MODE_CODE_LEFT;
            M_RIGHT:   c = MODE_CODE_RIGHT;
            M_REACHED: c = MODE_CODE_REACHED;
            M_FAILED:  c = MODE_CODE_FAILED;
            M_IDLE:    c = MODE_CODE_IDLE;
            default:   c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/rhp_if.sv -----
// ----------------------------------------------------------------------------
// rhp_if
// Valid/ready channels of the rudder homing positioner: ticks in,
// results out, configuration writes.
// ----------------------------------------------------------------------------
interface rhp_tick_if #(
    parameter int POS_W = 8
);
    logic                    valid;
    logic                    ready;
    logic                    left_limit;
    logic                    right_limit;
    logic signed [POS_W-1:0] position;
    logic                    command_valid;
    logic signed [POS_W-1:0] target_position;
    logic                    rehome;

    modport source (
        output valid, left_limit, right_limit, position,
        output command_valid, target_position, rehome,
        input  ready
    );
    modport sink (
        input  valid, left_limit, right_limit, position,
        input  command_valid, target_position, rehome,
        output ready
    );
endinterface

interface rhp_result_if #(
    parameter int POS_W = 8
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              drive;
    logic                    report_valid;
    logic                    report_kind;
    logic signed [POS_W-1:0] report_position;
    logic signed [POS_W-1:0] left_end;
    logic signed [POS_W-1:0] right_end;
    logic [2:0]              mode;

    modport source (
        output valid, drive, report_valid, report_kind, report_position,
        output left_end, right_end, mode,
        input  ready
    );
    modport sink (
        input  valid, drive, report_valid, report_kind, report_position,
        input  left_end, right_end, mode,
        output ready
    );
endinterface

interface rhp_cfg_if
    import rhp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rhp_step.sv -----
// ----------------------------------------------------------------------------
// rhp_step
// Next-state and result logic for one tick.
// ----------------------------------------------------------------------------
module rhp_step
    import rhp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
    input  rhp_cfg_t                        cfg_val,
    input  rhp_ctrl_t                       ctrl,
    input  logic [TIMER_BITS-1:0]           timer,
    input  logic [PAUSE_W-1:0]              settle_cnt,
    input  logic [PAUSE_W-1:0]              startup_cnt,
    input  logic signed [POSITION_BITS-1:0] left_end,
    input  logic signed [POSITION_BITS-1:0] right_end,
    input  logic signed [POSITION_BITS-1:0] target,
    input  logic                            left_limit,
    input  logic                            right_limit,
    input  logic signed [POSITION_BITS-1:0] position,
    input  logic                            command_valid,
    input  logic signed [POSITION_BITS-1:0] target_position,
    input  logic                            rehome,
    output rhp_ctrl_t                       ctrl_next,
    output logic [TIMER_BITS-1:0]           timer_next,
    output logic [PAUSE_W-1:0]              settle_cnt_next,
    output logic [PAUSE_W-1:0]              startup_cnt_next,
    output logic signed [POSITION_BITS-1:0] left_end_next,
    output logic signed [POSITION_BITS-1:0] right_end_next,
    output logic signed [POSITION_BITS-1:0] target_next,
    output logic                            report_valid,
    output logic                            report_kind
);

    localparam int CMP_W = (TIMER_BITS > STEER_W) ? TIMER_BITS : STEER_W;
    localparam logic signed [POSITION_BITS-1:0] POS_MAX =
        {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN =
        {1'b1, {(POSITION_BITS-1){1'b0}}};

    logic                  wd_fire;
    logic [TIMER_BITS-1:0] wd_timer;
    logic [PAUSE_W-1:0]    settle_inc;
    logic [PAUSE_W:0]      startup_plus;
    logic signed [POSITION_BITS-1:0] neg_pos;

    // Watchdog: fire above the limit, otherwise count up and saturate
    always_comb
    begin
        wd_fire = CMP_W'(timer) > CMP_W'(cfg_val.steer_timeout);
        if (wd_fire)
            wd_timer = '0;
        else if (timer != {TIMER_BITS{1'b1}})
            wd_timer = timer + 1'b1;
        else
            wd_timer = timer;
    end

    assign settle_inc   = (settle_cnt != {PAUSE_W{1'b1}}) ? settle_cnt + 1'b1 : settle_cnt;
    assign startup_plus = {1'b0, startup_cnt} + 1'b1;
    assign neg_pos      = (position == POS_MIN) ? POS_MAX : -position;

    always_comb
    begin
        ctrl_next        = ctrl;
        timer_next       = timer;
        settle_cnt_next  = settle_cnt;
        startup_cnt_next = startup_cnt;
        left_end_next    = left_end;
        right_end_next   = right_end;
        target_next      = target;
        report_valid     = 1'b0;
        report_kind      = KIND_REACHED;

        // The target is latched on any tick, ahead of the step
        if (command_valid)
        begin
            target_next           = target_position;
            ctrl_next.cmd_pending = 1'b1;
        end

        if (rehome)
        begin
            ctrl_next.mode          = M_STARTUP;
            ctrl_next.home          = H_FIND_LEFT;
            ctrl_next.drive         = DRIVE_STOP;
            ctrl_next.fail_reported = 1'b0;
            startup_cnt_next        = '0;
            timer_next              = '0;
            settle_cnt_next         = '0;
        end
        else
        begin
            unique case (ctrl.mode)
                M_STARTUP:
                begin
                    if (startup_plus > {1'b0, cfg_val.startup_pause})
                    begin
                        startup_cnt_next = '0;
                        timer_next       = '0;
                        ctrl_next.mode   = M_HOMING;
                    end
                    else
                        startup_cnt_next = startup_plus[PAUSE_W-1:0];
                end
                M_HOMING:
                begin
                    unique case (ctrl.home)
                        H_FIND_LEFT:
                        begin
                            timer_next = wd_timer;
                            if (wd_fire)
                                ctrl_next.mode = M_FAILED;
                            if (!left_limit)
                                ctrl_next.drive = DRIVE_LEFT;
                            else
                            begin
                                ctrl_next.home  = H_LEFT_SETTLE;
                                timer_next      = '0;
                                settle_cnt_next = '0;
                            end
                        end
                        H_LEFT_SETTLE:
                        begin
                            settle_cnt_next = settle_inc;
                            if (settle_cnt < cfg_val.settle_pause)
                                ctrl_next.drive = DRIVE_STOP;
                            else
                            begin
                                ctrl_next.home = H_FIND_RIGHT;
                                left_end_next  = position;
                            end
                        end
                        H_FIND_RIGHT:
                        begin
                            timer_next = wd_timer;
                            if (wd_fire)
                                ctrl_next.mode = M_FAILED;
                            if (!right_limit)
                                ctrl_next.drive = DRIVE_RIGHT;
                            else
                            begin
                                ctrl_next.home  = H_RIGHT_SETTLE;
                                timer_next      = '0;
                                settle_cnt_next = '0;
                            end
                        end
                        H_RIGHT_SETTLE:
                        begin
                            settle_cnt_next = settle_inc;
                            if (settle_cnt < cfg_val.settle_pause)
                            begin
                                ctrl_next.drive = DRIVE_STOP;
                                if (settle_inc == SETTLE_SAMPLE_A)
                                    right_end_next = position;
                                if (settle_inc == SETTLE_SAMPLE_B)
                                begin
                                    right_end_next = position;
                                    left_end_next  = neg_pos;
                                end
                            end
                            else
                                ctrl_next.home = H_FIND_MID;
                        end
                        H_FIND_MID:
                        begin
                            timer_next = wd_timer;
                            if (wd_fire)
                                ctrl_next.mode = M_FAILED;
                            if (!left_limit && position < 0)
                                ctrl_next.drive = DRIVE_LEFT;
                            else if (left_limit)
                            begin
                                // Hitting the left switch on the way to zero
                                ctrl_next.drive = DRIVE_STOP;
                                ctrl_next.mode  = M_FAILED;
                                timer_next      = '0;
                            end
                            else
                            begin
                                ctrl_next.drive = DRIVE_STOP;
                                ctrl_next.home  = H_MID_DONE;
                                settle_cnt_next = '0;
                                timer_next      = '0;
                            end
                        end
                        default:
                        begin
                            ctrl_next.mode = M_IDLE;
                            timer_next     = '0;
                        end
                    endcase
                end
                M_RIGHT:
                begin
                    timer_next = wd_timer;
                    if (wd_fire)
                        ctrl_next.mode = M_FAILED;
                    if (!right_limit && target_next < position)
                        ctrl_next.drive = DRIVE_RIGHT;
                    else
                        ctrl_next.mode = M_REACHED;
                end
                M_LEFT:
                begin
                    timer_next = wd_timer;
                    if (wd_fire)
                        ctrl_next.mode = M_FAILED;
                    if (!left_limit && target_next > position)
                        ctrl_next.drive = DRIVE_LEFT;
                    else
                        ctrl_next.mode = M_REACHED;
                end
                M_REACHED:
                begin
                    timer_next      = '0;
                    ctrl_next.drive = DRIVE_STOP;
                    report_valid    = 1'b1;
                    report_kind     = KIND_REACHED;
                    ctrl_next.mode  = M_IDLE;
                end
                M_FAILED:
                begin
                    timer_next      = '0;
                    ctrl_next.drive = DRIVE_STOP;
                    if (!ctrl.fail_reported)
                    begin
                        report_valid            = 1'b1;
                        report_kind             = KIND_FAILED;
                        ctrl_next.fail_reported = 1'b1;
                    end
                end
                M_IDLE:
                begin
                    timer_next = '0;
                    if (ctrl_next.cmd_pending)
                    begin
                        ctrl_next.cmd_pending = 1'b0;
                        if (target_next > position)
                            ctrl_next.mode = M_LEFT;
                        else if (target_next < position)
                            ctrl_next.mode = M_RIGHT;
                        else
                            ctrl_next.mode = M_REACHED;
                    end
                end
                default:
                    ctrl_next.mode = M_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/rudder_homing_positioner.sv -----
// ----------------------------------------------------------------------------
// rudder_homing_positioner
// Startup pause, limit-switch homing and target positioning of a rudder.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one transaction per timer tick, carrying the limit switches,
//            the encoder position, an optional new target and a rehome flag.
//   result : exactly one transaction per tick: motor drive, an optional
//            reached/failed report, the calibrated ends and the mode.
//   cfg    : register writes (0 steer_timeout, 1 startup_pause,
//            2 settle_pause); always ready. Write only while idle.
//   The result register holds a tick's result in the cycle after the
//   tick transaction. Throughput is one tick per cycle while the result
//   is drained: the whole step is one pass of combinational logic
//   between the state registers and the result register.
//   A new tick is taken while the result register is empty or is being
//   drained in the same cycle; a stalled receiver holds the result and
//   back-pressures the tick channel without losing anything.
//   Reset (rst_n low, async) returns to the startup pause with default
//   register values and ends at +100 / -100 (saturated to the width).
// ----------------------------------------------------------------------------
module rudder_homing_positioner
    import rhp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rhp_tick_if.sink     tick,
    rhp_result_if.source result,
    rhp_cfg_if.sink      cfg
);

    // Reset values of the ends, saturated to the position range
    localparam int POS_MAX_I = (1 << (POSITION_BITS - 1)) - 1;
    localparam int POS_MIN_I = -POS_MAX_I - 1;
    localparam int LEFT_RST_I  = (LEFT_END_RST > POS_MAX_I) ? POS_MAX_I : LEFT_END_RST;
    localparam int RIGHT_RST_I = (RIGHT_END_RST < POS_MIN_I) ? POS_MIN_I : RIGHT_END_RST;
    localparam logic signed [POSITION_BITS-1:0] LEFT_RST  = POSITION_BITS'(LEFT_RST_I);
    localparam logic signed [POSITION_BITS-1:0] RIGHT_RST = POSITION_BITS'(RIGHT_RST_I);

    rhp_cfg_t                        cfg_reg;
    rhp_ctrl_t                       ctrl_reg, ctrl_next;
    logic [TIMER_BITS-1:0]           timer_reg, timer_next;
    logic [PAUSE_W-1:0]              settle_cnt_reg, settle_cnt_next;
    logic [PAUSE_W-1:0]              startup_cnt_reg, startup_cnt_next;
    logic signed [POSITION_BITS-1:0] left_end_reg, left_end_next;
    logic signed [POSITION_BITS-1:0] right_end_reg, right_end_next;
    logic signed [POSITION_BITS-1:0] target_reg, target_next;
    logic                            rep_valid, rep_kind;

    // Result register
    logic                            out_valid_reg;
    logic [1:0]                      out_drive_reg;
    logic                            out_rep_valid_reg;
    logic                            out_rep_kind_reg;
    logic signed [POSITION_BITS-1:0] out_rep_pos_reg;
    logic signed [POSITION_BITS-1:0] out_left_reg;
    logic signed [POSITION_BITS-1:0] out_right_reg;
    logic [2:0]                      out_mode_reg;

    logic tick_take;

    // Accept when the result slot is free or drains this cycle
    assign tick.ready = !out_valid_reg || result.ready;
    assign tick_take  = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;

    // Configuration registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steer_timeout <= STEER_TIMEOUT_RST;
            cfg_reg.startup_pause <= STARTUP_PAUSE_RST;
            cfg_reg.settle_pause  <= SETTLE_PAUSE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STEER_TIMEOUT: cfg_reg.steer_timeout <= cfg.data[STEER_W-1:0];
                REG_STARTUP_PAUSE: cfg_reg.startup_pause <= cfg.data[PAUSE_W-1:0];
                REG_SETTLE_PAUSE:  cfg_reg.settle_pause  <= cfg.data[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    rhp_step #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_step (
        .cfg_val          (cfg_reg),
        .ctrl             (ctrl_reg),
        .timer            (timer_reg),
        .settle_cnt       (settle_cnt_reg),
        .startup_cnt      (startup_cnt_reg),
        .left_end         (left_end_reg),
        .right_end        (right_end_reg),
        .target           (target_reg),
        .left_limit       (tick.left_limit),
        .right_limit      (tick.right_limit),
        .position         (tick.position),
        .command_valid    (tick.command_valid),
        .target_position  (tick.target_position),
        .rehome           (tick.rehome),
        .ctrl_next        (ctrl_next),
        .timer_next       (timer_next),
        .settle_cnt_next  (settle_cnt_next),
        .startup_cnt_next (startup_cnt_next),
        .left_end_next    (left_end_next),
        .right_end_next   (right_end_next),
        .target_next      (target_next),
        .report_valid     (rep_valid),
        .report_kind      (rep_kind)
    );

    // Block state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.mode          <= M_STARTUP;
            ctrl_reg.home          <= H_FIND_LEFT;
            ctrl_reg.drive         <= DRIVE_STOP;
            ctrl_reg.cmd_pending   <= 1'b0;
            ctrl_reg.fail_reported <= 1'b0;
            timer_reg              <= '0;
            settle_cnt_reg         <= '0;
            startup_cnt_reg        <= '0;
            left_end_reg           <= LEFT_RST;
            right_end_reg          <= RIGHT_RST;
            target_reg             <= '0;
        end
        else if (tick_take)
        begin
            ctrl_reg        <= ctrl_next;
            timer_reg       <= timer_next;
            settle_cnt_reg  <= settle_cnt_next;
            startup_cnt_reg <= startup_cnt_next;
            left_end_reg    <= left_end_next;
            right_end_reg   <= right_end_next;
            target_reg      <= target_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick_take)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload; report fields read zero when no report goes out
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            out_drive_reg     <= ctrl_next.drive;
            out_rep_valid_reg <= rep_valid;
            out_rep_kind_reg  <= rep_valid ? rep_kind : KIND_REACHED;
            out_rep_pos_reg   <= rep_valid ? tick.position : '0;
            out_left_reg      <= left_end_next;
            out_right_reg     <= right_end_next;
            out_mode_reg      <= mode_code(ctrl_next.mode);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.drive           = out_drive_reg;
    assign result.report_valid    = out_rep_valid_reg;
    assign result.report_kind     = out_rep_kind_reg;
    assign result.report_position = out_rep_pos_reg;
    assign result.left_end        = out_left_reg;
    assign result.right_end       = out_right_reg;
    assign result.mode            = out_mode_reg;

endmodule

// ----- tb/rudder_homing_positioner_tb.sv -----
// ----------------------------------------------------------------------------
// rudder_homing_positioner_tb
// Self-checking bench for the rudder homing positioner. A software twin of
// the block predicts one step result per accepted tick. A simple rudder plant
// that follows the predicted motor drive feeds the block. The plant walks it
// through startup, homing, targeting, watchdog failures and rehome across
// several register settings, while both channels idle at random.
// ----------------------------------------------------------------------------
module rudder_homing_positioner_tb
    import rhp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W       = 8;
    localparam int STALL_LIMIT = 2000;   // cycles with no transaction at all
    localparam int POS_HI      = 127;
    localparam int POS_LO      = -128;

    typedef struct packed {
        logic              left_limit;
        logic              right_limit;
        logic signed [7:0] position;
        logic              command_valid;
        logic signed [7:0] target_position;
        logic              rehome;
    } tick_item_t;

    typedef struct packed {
        logic [1:0]        drive;
        logic              report_valid;
        logic              report_kind;
        logic signed [7:0] report_position;
        logic signed [7:0] left_end;
        logic signed [7:0] right_end;
        logic [2:0]        mode;
    } step_result_t;

    // ------------------------------------------------------------------------
    // Software twin of the positioner: register copies, control state and
    // the queue of step results still owed by the block.
    // ------------------------------------------------------------------------
    class rudder_twin;
        logic [STEER_W-1:0] steer_timeout;
        logic [PAUSE_W-1:0] startup_pause;
        logic [PAUSE_W-1:0] settle_pause;
        logic [2:0]         main_mode;
        home_t              home_step;
        logic [15:0]        motion_timer;
        logic [7:0]         settle_count;
        logic [7:0]         startup_count;
        int                 left_end;
        int                 right_end;
        int                 target;
        bit                 cmd_pending;
        bit                 fail_reported;
        logic [1:0]         drive;
        step_result_t       step_results_due[$];
        int                 fails;
        int                 ticks_taken;
        int                 results_checked;
        int                 reached_reports;
        int                 failed_reports;

        function new();
            steer_timeout = STEER_TIMEOUT_RST;
            startup_pause = STARTUP_PAUSE_RST;
            settle_pause  = SETTLE_PAUSE_RST;
            main_mode     = MODE_CODE_STARTUP;
            home_step     = H_FIND_LEFT;
            motion_timer  = '0;
            settle_count  = '0;
            startup_count = '0;
            left_end      = LEFT_END_RST;
            right_end     = RIGHT_END_RST;
            target        = 0;
            cmd_pending   = 1'b0;
            fail_reported = 1'b0;
            drive         = DRIVE_STOP;
            fails         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STEER_TIMEOUT: steer_timeout = data;
                REG_STARTUP_PAUSE: startup_pause = data[PAUSE_W-1:0];
                REG_SETTLE_PAUSE:  settle_pause  = data[PAUSE_W-1:0];
                default: ;
            endcase
        endfunction

        // Motion watchdog; the timer sticks at all ones
        function void run_watchdog();
            if (motion_timer > steer_timeout) begin
                motion_timer = '0;
                main_mode    = MODE_CODE_FAILED;
            end else if (motion_timer != 16'hffff) begin
                motion_timer++;
            end
        endfunction

        function logic [7:0] bump_settle();
            logic [7:0] prior;
            prior = settle_count;
            if (settle_count != 8'hff)
                settle_count++;
            return prior;
        endfunction

        function void take_tick(tick_item_t t);
            int           pos;
            bit           rep;
            logic         kind;
            step_result_t r;
            pos  = $signed(t.position);
            rep  = 1'b0;
            kind = KIND_REACHED;
            ticks_taken++;

            if (t.command_valid) begin
                target      = $signed(t.target_position);
                cmd_pending = 1'b1;
            end

            if (t.rehome) begin
                main_mode     = MODE_CODE_STARTUP;
                startup_count = '0;
                motion_timer  = '0;
                settle_count  = '0;
                home_step     = H_FIND_LEFT;
                drive         = DRIVE_STOP;
                fail_reported = 1'b0;
            end else begin
                case (main_mode)
                    MODE_CODE_STARTUP: begin
                        if (int'(startup_count) + 1 > int'(startup_pause)) begin
                            startup_count = '0;
                            motion_timer  = '0;
                            main_mode     = MODE_CODE_HOMING;
                        end else begin
                            startup_count++;
                        end
                    end
                    MODE_CODE_HOMING: begin
                        case (home_step)
                            H_FIND_LEFT: begin
                                run_watchdog();
                                if (!t.left_limit) begin
                                    drive = DRIVE_LEFT;
                                end else begin
                                    home_step    = H_LEFT_SETTLE;
                                    motion_timer = '0;
                                    settle_count = '0;
                                end
                            end
                            H_LEFT_SETTLE: begin
                                if (bump_settle() < settle_pause) begin
                                    drive = DRIVE_STOP;
                                end else begin
                                    home_step = H_FIND_RIGHT;
                                    left_end  = pos;
                                end
                            end
                            H_FIND_RIGHT: begin
                                run_watchdog();
                                if (!t.right_limit) begin
                                    drive = DRIVE_RIGHT;
                                end else begin
                                    home_step    = H_RIGHT_SETTLE;
                                    settle_count = '0;
                                    motion_timer = '0;
                                end
                            end
                            H_RIGHT_SETTLE: begin
                                if (bump_settle() < settle_pause) begin
                                    drive = DRIVE_STOP;
                                    if (settle_count == SETTLE_SAMPLE_A)
                                        right_end = pos;
                                    if (settle_count == SETTLE_SAMPLE_B) begin
                                        right_end = pos;
                                        // mirrored left end, clipped at +127
                                        left_end  = (-right_end > POS_HI) ? POS_HI : -right_end;
                                    end
                                end else begin
                                    home_step = H_FIND_MID;
                                end
                            end
                            H_FIND_MID: begin
                                run_watchdog();
                                if (!t.left_limit && pos < 0) begin
                                    drive = DRIVE_LEFT;
                                end else if (t.left_limit) begin
                                    drive        = DRIVE_STOP;
                                    main_mode    = MODE_CODE_FAILED;
                                    motion_timer = '0;
                                end else begin
                                    drive        = DRIVE_STOP;
                                    home_step    = H_MID_DONE;
                                    settle_count = '0;
                                    motion_timer = '0;
                                end
                            end
                            default: begin
                                main_mode    = MODE_CODE_IDLE;
                                motion_timer = '0;
                            end
                        endcase
                    end
                    MODE_CODE_RIGHT: begin
                        run_watchdog();
                        if (!t.right_limit && target < pos)
                            drive = DRIVE_RIGHT;
                        else
                            main_mode = MODE_CODE_REACHED;
                    end
                    MODE_CODE_LEFT: begin
                        run_watchdog();
                        if (!t.left_limit && target > pos)
                            drive = DRIVE_LEFT;
                        else
                            main_mode = MODE_CODE_REACHED;
                    end
                    MODE_CODE_REACHED: begin
                        motion_timer = '0;
                        drive        = DRIVE_STOP;
                        rep          = 1'b1;
                        kind         = KIND_REACHED;
                        main_mode    = MODE_CODE_IDLE;
                    end
                    MODE_CODE_FAILED: begin
                        motion_timer = '0;
                        drive        = DRIVE_STOP;
                        if (!fail_reported) begin
                            rep           = 1'b1;
                            kind          = KIND_FAILED;
                            fail_reported = 1'b1;
                        end
                    end
                    MODE_CODE_IDLE: begin
                        motion_timer = '0;
                        if (cmd_pending) begin
                            cmd_pending = 1'b0;
                            if (target > pos)
                                main_mode = MODE_CODE_LEFT;
                            else if (target < pos)
                                main_mode = MODE_CODE_RIGHT;
                            else
                                main_mode = MODE_CODE_REACHED;
                        end
                    end
                    default: main_mode = MODE_CODE_IDLE;
                endcase
            end

            if (rep && kind == KIND_FAILED)
                failed_reports++;
            else if (rep)
                reached_reports++;

            r.drive           = drive;
            r.report_valid    = rep;
            r.report_kind     = rep ? kind : KIND_REACHED;
            r.report_position = rep ? pos[7:0] : 8'sd0;
            r.left_end        = left_end[7:0];
            r.right_end       = right_end[7:0];
            r.mode            = main_mode;
            step_results_due.push_back(r);
        endfunction

        function void check_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(step_result_t got);
            step_result_t want;
            if (step_results_due.size() == 0) begin
                $error("step result with no tick waiting for it");
                fails++;
                return;
            end
            want = step_results_due.pop_front();
            results_checked++;
            check_field("drive", want.drive, got.drive);
            check_field("report_valid", want.report_valid, got.report_valid);
            check_field("report_kind", want.report_kind, got.report_kind);
            check_field("report_position", want.report_position, got.report_position);
            check_field("left_end", want.left_end, got.left_end);
            check_field("right_end", want.right_end, got.right_end);
            check_field("mode", want.mode, got.mode);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    rhp_tick_if   #(.POS_W(POS_W)) tick_ch ();
    rhp_result_if #(.POS_W(POS_W)) res_ch ();
    rhp_cfg_if                     cfg_ch ();

    rudder_homing_positioner #(
        .POSITION_BITS (POS_W),
        .TIMER_BITS    (16)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    rudder_twin twin = new();

    // Set for the tail of the run: no gaps on the tick side, no stalls on
    // the result side.
    bit calm;

    // Rudder plant: encoder position and where the end switches close
    int plant_pos;
    int left_stop;
    int right_stop;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, none when calm.
    // Every accepted result goes straight to the twin for checking.
    // ------------------------------------------------------------------------
    int stall_left;

    always @(posedge clk)
    begin
        if (calm) begin
            res_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 11) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        step_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.drive           = res_ch.drive;
            got.report_valid    = res_ch.report_valid;
            got.report_kind     = res_ch.report_kind;
            got.report_position = res_ch.report_position;
            got.left_end        = res_ch.left_end;
            got.right_end       = res_ch.right_end;
            got.mode            = res_ch.mode;
            twin.check_result(got);
        end
    end

    // Hang detector: any transaction on any channel restarts the count
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else if (rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // One tick transaction, after an optional random gap. valid stays high
    // from one tick to the next when there is no gap.
    task automatic send_tick(tick_item_t t);
        if (!calm && $urandom_range(0, 7) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.left_limit      <= t.left_limit;
        tick_ch.right_limit     <= t.right_limit;
        tick_ch.position        <= t.position;
        tick_ch.command_valid   <= t.command_valid;
        tick_ch.target_position <= t.target_position;
        tick_ch.rehome          <= t.rehome;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        twin.take_tick(t);
    endtask

    // valid stays high across back-to-back writes; the caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        twin.write_reg(idx, data);
    endtask

    // Hold the tick side until every owed result is back, then let the result register empty.
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (twin.step_results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(logic [15:0] steer, logic [7:0] startup, logic [7:0] settle);
        drain_results();
        write_reg(REG_STEER_TIMEOUT, steer);
        write_reg(REG_STARTUP_PAUSE, {8'd0, startup});
        write_reg(REG_SETTLE_PAUSE, {8'd0, settle});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void pick_stops();
        left_stop  = ($urandom_range(0, 3) == 0) ? POS_HI : $urandom_range(0, 120);
        right_stop = ($urandom_range(0, 3) == 0) ? POS_LO : -int'($urandom_range(1, 120));
    endfunction

    function automatic tick_item_t mk_tick(bit l, bit r, int pos, bit cmd, int tgt, bit rh);
        tick_item_t t;
        t.left_limit      = l;
        t.right_limit     = r;
        t.position        = pos[7:0];
        t.command_valid   = cmd;
        t.target_position = tgt[7:0];
        t.rehome          = rh;
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Next tick from the plant. The rudder moves by 1..4 counts in the
    // direction the twin says the motor is driven; end switches close past
    // the stops. A few ticks carry a glitched encoder value or a bouncing
    // switch. Commands come mostly while idle; rehome mostly after failure.
    // ------------------------------------------------------------------------
    function automatic tick_item_t next_tick();
        tick_item_t t;
        int         stride;
        int         offset;
        int         tgt;
        int         cmd_pct;
        stride = $urandom_range(1, 4);
        if (twin.drive == DRIVE_LEFT)
            plant_pos = plant_pos + stride;
        else if (twin.drive == DRIVE_RIGHT)
            plant_pos = plant_pos - stride;
        if (plant_pos > POS_HI) plant_pos = POS_HI;
        if (plant_pos < POS_LO) plant_pos = POS_LO;

        t.position    = plant_pos[7:0];
        t.left_limit  = (plant_pos >= left_stop);
        t.right_limit = (plant_pos <= right_stop);
        if ($urandom_range(0, 99) < 4) t.position    = 8'($urandom);
        if ($urandom_range(0, 99) < 3) t.left_limit  = !t.left_limit;
        if ($urandom_range(0, 99) < 3) t.right_limit = !t.right_limit;

        case (twin.main_mode)
            MODE_CODE_IDLE:                  cmd_pct = 45;
            MODE_CODE_LEFT, MODE_CODE_RIGHT: cmd_pct = 4;   // re-aim mid motion
            default:                         cmd_pct = 2;
        endcase
        t.command_valid = ($urandom_range(0, 99) < cmd_pct);

        case ($urandom_range(0, 9))
            0, 1, 2: tgt = $signed(8'($urandom));
            3:       tgt = plant_pos;                        // already there
            default: begin
                offset = $urandom_range(0, 120);
                tgt    = plant_pos + offset - 60;
            end
        endcase
        if (tgt > POS_HI) tgt = POS_HI;
        if (tgt < POS_LO) tgt = POS_LO;
        t.target_position = tgt[7:0];

        if (twin.main_mode == MODE_CODE_FAILED)
            t.rehome = ($urandom_range(0, 5) == 0);
        else
            t.rehome = ($urandom_range(0, 299) == 0);
        if (t.rehome)
            pick_stops();
        return t;
    endfunction

    // One register setting followed by plant-driven ticks; the sender waits
    // once for the block to drain somewhere in the middle.
    task automatic run_phase(logic [15:0] steer, logic [7:0] startup, logic [7:0] settle,
                             int count, int calm_tail);
        int hold_at;
        program_regs(steer, startup, settle);
        pick_stops();
        hold_at = $urandom_range(10, count - 10);
        for (int i = 0; i < count; i++) begin
            if (i == count - calm_tail)
                calm = 1'b1;
            if (i == hold_at)
                drain_results();
            send_tick(next_tick());
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed opening with no pauses and a watchdog limit of 3: a full
    // homing with the left end recorded at +127, a left switch during the zero
    // search (failure, one report, then silence), rehome with a target
    // still pending, re-aiming during a motion, a target equal to the
    // position, and a left switch ending a leftward move.
    // ------------------------------------------------------------------------
    task automatic directed_ticks();
        program_regs(16'd3, 8'd0, 8'd0);
        send_tick(mk_tick(0, 0, 127, 1, -128, 0));   // startup done, target latched
        send_tick(mk_tick(0, 0, 50, 0, 0, 0));       // seeking left end
        send_tick(mk_tick(1, 0, -128, 0, 0, 0));     // left switch closes
        send_tick(mk_tick(1, 0, 127, 0, 0, 0));      // left end recorded at +127
        send_tick(mk_tick(0, 0, 10, 0, 0, 0));       // seeking right end
        send_tick(mk_tick(0, 1, -128, 1, 127, 0));   // right switch, new target
        send_tick(mk_tick(0, 1, -1, 0, 0, 0));       // zero settle: no sampling
        send_tick(mk_tick(0, 0, -1, 0, 0, 0));       // zero search drives left
        send_tick(mk_tick(1, 0, 5, 0, 0, 0));        // left switch here is a failure
        send_tick(mk_tick(0, 0, 5, 0, 0, 0));        // single failure report
        send_tick(mk_tick(0, 0, 6, 0, 0, 0));        // latched, no second report
        send_tick(mk_tick(0, 0, 0, 0, 0, 1));        // rehome
        send_tick(mk_tick(1, 0, 0, 0, 0, 0));
        send_tick(mk_tick(1, 0, 0, 0, 0, 0));
        send_tick(mk_tick(0, 1, 3, 0, 0, 0));
        send_tick(mk_tick(0, 1, -4, 0, 0, 0));
        send_tick(mk_tick(0, 0, -4, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, 0, 0, 0));        // zero found
        send_tick(mk_tick(0, 0, 0, 0, 0, 0));        // homed, now idle
        send_tick(mk_tick(0, 0, 0, 0, 0, 0));        // pending target: move left
        send_tick(mk_tick(0, 0, 20, 1, -128, 0));    // re-aimed behind us: reached
        send_tick(mk_tick(0, 0, 21, 0, 0, 0));       // reached report
        send_tick(mk_tick(0, 0, 21, 1, 21, 0));      // target equals position
        send_tick(mk_tick(0, 1, -128, 1, -100, 0));
        send_tick(mk_tick(0, 1, -128, 0, 0, 0));     // move left toward -100
        send_tick(mk_tick(1, 0, -120, 0, 0, 0));     // left switch stops it
        send_tick(mk_tick(0, 0, -120, 0, 0, 0));
        plant_pos = -120;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        calm                    = 1'b0;
        stall_left              = 0;
        quiet_cycles            = 0;
        plant_pos               = 0;
        left_stop               = POS_HI;
        right_stop              = POS_LO;
        tick_ch.valid           = 1'b0;
        tick_ch.left_limit      = 1'b0;
        tick_ch.right_limit     = 1'b0;
        tick_ch.position        = '0;
        tick_ch.command_valid   = 1'b0;
        tick_ch.target_position = '0;
        tick_ch.rehome          = 1'b0;
        res_ch.ready            = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_STEER_TIMEOUT;
        cfg_ch.data             = '0;
        rst_n                   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_ticks();
        // watchdog off (saturating timer never exceeds all ones), settle
        // long enough to sample the right end twice
        run_phase(16'hffff, 8'd0, 8'd21, 260, 0);
        // longest startup, watchdog firing on the second motion tick
        run_phase(16'd0, 8'd255, 8'd5, 280, 0);
        // longest settle at both ends
        run_phase(16'd300, 8'd1, 8'd255, 560, 0);
        // tight watchdog; the tail runs with no gaps and no stalls
        run_phase(16'd40, 8'd7, 8'd12, 330, 150);
        drain_results();

        $display("covered %0d ticks, %0d step results checked, %0d reached and %0d failure reports",
                 twin.ticks_taken, twin.results_checked, twin.reached_reports,
                 twin.failed_reports);
        $display("register settings: steer timeout 3/65535/0/300/40, pauses from 0 to 255");
        if (twin.fails == 0 && twin.step_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
